@@ rtl/core/arln_pkg.sv @@
// arln_pkg: shared widths, codes, reset values and transaction types for the
// auto-ranging level normalizer; used by every module under rtl/core
package arln_pkg;

  localparam int SAMPLE_BITS    = 12;
  localparam int LEVEL_BITS     = 16;
  localparam int TIME_BITS      = 32;
  localparam int THRESH_BITS    = 12;
  localparam int CFG_DATA_BITS  = 32;
  localparam int CFG_INDEX_BITS = 2;
  localparam int QUEUE_DEPTH    = 2;

  // register indexes
  localparam logic [CFG_INDEX_BITS-1:0] CFG_QUIET_LEVEL    = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_MIN_SPAN       = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_DECAY_INTERVAL = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_INVERT_LEVEL   = 2'd3;

  localparam logic [THRESH_BITS-1:0] QUIET_LEVEL_RESET    = 12'd250;
  localparam logic [THRESH_BITS-1:0] MIN_SPAN_RESET       = 12'd300;
  localparam logic [TIME_BITS-1:0]   DECAY_INTERVAL_RESET = 32'd4000;
  localparam logic                   INVERT_LEVEL_RESET   = 1'b1;

  // span / 40 taken as (span >> 3) / 5
  localparam int DECAY_SHIFT = 3;
  localparam int DECAY_ODD   = 5;

  // how the back end forms the level
  localparam logic [1:0] JOB_ZERO = 2'd0;
  localparam logic [1:0] JOB_ONES = 2'd1;
  localparam logic [1:0] JOB_DIV  = 2'd2;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample;
    logic [TIME_BITS-1:0]   time_ms;
  } item_t;

  typedef struct packed {
    logic [LEVEL_BITS-1:0]  level;
    logic                   line_active;
    logic                   range_ready;
    logic [SAMPLE_BITS-1:0] low_seen;
    logic [SAMPLE_BITS-1:0] high_seen;
  } result_t;

  typedef struct packed {
    logic [1:0]             mode;
    logic [SAMPLE_BITS-1:0] numer;
    logic [SAMPLE_BITS-1:0] span;
    logic                   line_active;
    logic                   range_ready;
    logic [SAMPLE_BITS-1:0] low_seen;
    logic [SAMPLE_BITS-1:0] high_seen;
  } job_t;

endpackage

@@ rtl/core/arln_front.sv @@
// arln_front: accepts sample transactions, tracks and decays the observed range,
// classifies each sample into a job for the back end; holds the config registers
// depends on arln_pkg
module arln_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 push,
  output logic                                 full,
  input  arln_pkg::item_t                      item,
  input  logic                                 wr_en,
  input  logic [arln_pkg::CFG_INDEX_BITS-1:0]  wr_index,
  input  logic [arln_pkg::CFG_DATA_BITS-1:0]   wr_data,
  output arln_pkg::job_t                       job,
  output logic                                 job_push,
  input  logic                                 job_full
);

  localparam int SB       = arln_pkg::SAMPLE_BITS;
  localparam int TB       = arln_pkg::TIME_BITS;
  localparam int HB       = arln_pkg::THRESH_BITS;
  localparam int W        = SB - arln_pkg::DECAY_SHIFT;
  localparam int DIV_SHIFT = W + 3;
  localparam int PW       = 2 * W + 3;
  localparam logic [PW-1:0] RECIP = PW'((2 ** DIV_SHIFT) / arln_pkg::DECAY_ODD);

  localparam logic [2:0] F_IDLE  = 3'd0;
  localparam logic [2:0] F_DECAY = 3'd1;
  localparam logic [2:0] F_STEP  = 3'd2;
  localparam logic [2:0] F_CLASS = 3'd3;
  localparam logic [2:0] F_PUSH  = 3'd4;

  logic [2:0]    state;
  logic [SB-1:0] sample_r;
  logic [TB-1:0] now_r;
  logic [SB-1:0] low_bound;
  logic [SB-1:0] high_bound;
  logic [TB-1:0] last_decay;
  logic          seeded;
  logic          decay_go;
  logic [PW-1:0] prod;
  logic [HB-1:0] quiet_level;
  logic [HB-1:0] min_span;
  logic [TB-1:0] decay_interval;
  logic          invert_level;
  arln_pkg::job_t job_r;

  logic [TB-1:0] elapsed;
  logic [SB-1:0] span_cur;
  logic [W-1:0]  span_hi;
  logic [W-1:0]  q_est;
  logic [W+2:0]  qx5;
  logic [W+2:0]  rem;
  logic [SB-1:0] step;
  logic [SB:0]   diff_up;
  logic [SB:0]   diff_dn;
  logic [SB:0]   d;
  logic          d_low;
  logic          d_high;
  logic          ready;
  logic [1:0]    mode;

  always_comb begin
    elapsed  = now_r - last_decay;
    span_cur = high_bound - low_bound;
    span_hi  = span_cur[SB-1:arln_pkg::DECAY_SHIFT];
    q_est    = prod[DIV_SHIFT +: W];
    qx5      = (W+3)'(q_est) * (W+3)'(arln_pkg::DECAY_ODD);
    rem      = (W+3)'(span_hi) - qx5;
    step     = (rem >= (W+3)'(arln_pkg::DECAY_ODD)) ? SB'(q_est) + SB'(1) : SB'(q_est);
    diff_up  = {1'b0, sample_r} - {1'b0, low_bound};
    diff_dn  = {1'b0, high_bound} - {1'b0, sample_r};
    d        = invert_level ? diff_dn : diff_up;
    d_low    = d[SB] || (d == '0);
    d_high   = !d[SB] && (d[SB-1:0] >= span_cur);
    ready    = span_cur >= min_span;
    if (!ready) begin
      mode = arln_pkg::JOB_ZERO;
    end else if (span_cur == '0) begin
      mode = invert_level ? arln_pkg::JOB_ONES : arln_pkg::JOB_ZERO;
    end else if (d_low) begin
      mode = arln_pkg::JOB_ZERO;
    end else if (d_high) begin
      mode = arln_pkg::JOB_ONES;
    end else begin
      mode = arln_pkg::JOB_DIV;
    end
  end

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      quiet_level    <= arln_pkg::QUIET_LEVEL_RESET;
      min_span       <= arln_pkg::MIN_SPAN_RESET;
      decay_interval <= arln_pkg::DECAY_INTERVAL_RESET;
      invert_level   <= arln_pkg::INVERT_LEVEL_RESET;
    end else if (wr_en) begin
      case (wr_index)
        arln_pkg::CFG_QUIET_LEVEL:    quiet_level    <= wr_data[HB-1:0];
        arln_pkg::CFG_MIN_SPAN:       min_span       <= wr_data[HB-1:0];
        arln_pkg::CFG_DECAY_INTERVAL: decay_interval <= wr_data[TB-1:0];
        arln_pkg::CFG_INVERT_LEVEL:   invert_level   <= wr_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= F_IDLE;
      low_bound  <= '0;
      high_bound <= '1;
      last_decay <= '0;
      seeded     <= 1'b0;
      decay_go   <= 1'b0;
    end else begin
      case (state)
        F_IDLE: begin
          if (push) begin
            sample_r <= item.sample;
            now_r    <= item.time_ms;
            seeded   <= 1'b1;
            if (!seeded) begin
              low_bound  <= item.sample;
              high_bound <= item.sample;
            end else begin
              if (item.sample < low_bound) begin
                low_bound <= item.sample;
              end
              if (item.sample > high_bound) begin
                high_bound <= item.sample;
              end
            end
            state <= F_DECAY;
          end
        end
        F_DECAY: begin
          prod <= PW'(span_hi) * RECIP;
          if (elapsed >= decay_interval) begin
            last_decay <= now_r;
            decay_go   <= span_cur > min_span;
          end else begin
            decay_go <= 1'b0;
          end
          state <= F_STEP;
        end
        F_STEP: begin
          if (decay_go) begin
            low_bound  <= low_bound + step;
            high_bound <= high_bound - step;
          end
          state <= F_CLASS;
        end
        F_CLASS: begin
          job_r.mode        <= mode;
          job_r.numer       <= d[SB-1:0];
          job_r.span        <= span_cur;
          job_r.line_active <= sample_r > quiet_level;
          job_r.range_ready <= ready;
          job_r.low_seen    <= low_bound;
          job_r.high_seen   <= high_bound;
          state             <= F_PUSH;
        end
        F_PUSH: begin
          if (!job_full) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  assign full     = state != F_IDLE;
  assign job_push = (state == F_PUSH) && !job_full;
  assign job      = job_r;

endmodule

@@ rtl/core/arln_queue.sv @@
// arln_queue: short register queue of jobs between front and back end
// depends on arln_pkg
module arln_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr,
  input  arln_pkg::job_t wr_job,
  output logic           q_full,
  input  logic           rd,
  output arln_pkg::job_t rd_job,
  output logic           q_empty
);

  localparam int DEPTH = arln_pkg::QUEUE_DEPTH;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  arln_pkg::job_t entries [DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [AW:0]    count;

  always_ff @(posedge clk) begin
    if (wr) begin
      entries[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (wr && !rd) begin
        count <= count + (AW+1)'(1);
      end else if (rd && !wr) begin
        count <= count - (AW+1)'(1);
      end
    end
  end

  assign rd_job  = entries[rd_ptr];
  assign q_full  = count == (AW+1)'(DEPTH);
  assign q_empty = count == '0;

endmodule

@@ rtl/core/arln_back.sv @@
// arln_back: forms the level, with a restoring divider (one quotient bit a cycle) when a divide
// is needed, and holds the finished result in an output register; depends on arln_pkg
module arln_back (
  input  logic                clk,
  input  logic                rst,
  input  arln_pkg::job_t      job,
  input  logic                job_empty,
  output logic                job_pop,
  output arln_pkg::result_t   result,
  output logic                empty,
  input  logic                pop
);

  localparam int SB = arln_pkg::SAMPLE_BITS;
  localparam int LB = arln_pkg::LEVEL_BITS;
  localparam int CW = $clog2(LB + 1);

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_DIV  = 2'd1;
  localparam logic [1:0] B_DONE = 2'd2;

  logic [1:0]        state;
  arln_pkg::job_t    job_r;
  logic [SB-1:0]     rem;
  logic [LB-1:0]     quo;
  logic [CW-1:0]     cnt;
  arln_pkg::result_t out_r;
  logic              out_valid;

  logic [SB+LB-1:0]  numer;
  logic [SB+1:0]     trial;
  logic [LB-1:0]     level;

  always_comb begin
    numer = {job.numer, {LB{1'b0}}} - (SB+LB)'(job.numer);
    trial = {1'b0, rem, quo[LB-1]} - {2'b00, job_r.span};
    case (job_r.mode)
      arln_pkg::JOB_ONES: level = '1;
      arln_pkg::JOB_DIV:  level = quo;
      default:            level = '0;
    endcase
  end

  assign job_pop = (state == B_IDLE) && !job_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      case (state)
        B_IDLE: begin
          if (!job_empty) begin
            job_r <= job;
            rem   <= numer[SB+LB-1:LB];
            quo   <= numer[LB-1:0];
            cnt   <= '0;
            state <= (job.mode == arln_pkg::JOB_DIV) ? B_DIV : B_DONE;
          end
        end
        B_DIV: begin
          if (!trial[SB+1]) begin
            rem <= trial[SB-1:0];
            quo <= {quo[LB-2:0], 1'b1};
          end else begin
            rem <= {rem[SB-2:0], quo[LB-1]};
            quo <= {quo[LB-2:0], 1'b0};
          end
          cnt <= cnt + CW'(1);
          if (cnt == CW'(LB - 1)) begin
            state <= B_DONE;
          end
        end
        B_DONE: begin
          if (!out_valid || pop) begin
            state <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == B_DONE) && (!out_valid || pop)) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == B_DONE) && (!out_valid || pop)) begin
      out_r.level       <= level;
      out_r.line_active <= job_r.line_active;
      out_r.range_ready <= job_r.range_ready;
      out_r.low_seen    <= job_r.low_seen;
      out_r.high_seen   <= job_r.high_seen;
    end
  end

  assign result = out_r;
  assign empty  = !out_valid;

endmodule

@@ rtl/core/auto_range_level_normalizer.sv @@
// auto_range_level_normalizer: an accepted transaction passes the front end states
// (decay, step, classify, push), the job queue and the back end, which runs its
// 16-step divider only when the level needs a divide; the front end takes a new
// transaction only after its last job is pushed, which waits while the queue is full
// reset (rst, synchronous): config to defaults, range unseeded, queue and output empty
// depends on arln_pkg, arln_front, arln_queue, arln_back
module auto_range_level_normalizer (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 push,
  output logic                                 full,
  input  arln_pkg::item_t                      item,
  output logic                                 empty,
  input  logic                                 pop,
  output arln_pkg::result_t                    result,
  input  logic                                 wr_en,
  input  logic [arln_pkg::CFG_INDEX_BITS-1:0]  wr_index,
  input  logic [arln_pkg::CFG_DATA_BITS-1:0]   wr_data
);

  arln_pkg::job_t front_job;
  arln_pkg::job_t back_job;
  logic           job_push;
  logic           job_full;
  logic           job_pop;
  logic           job_empty;

  arln_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .item     (item),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .job      (front_job),
    .job_push (job_push),
    .job_full (job_full)
  );

  arln_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (job_push),
    .wr_job  (front_job),
    .q_full  (job_full),
    .rd      (job_pop),
    .rd_job  (back_job),
    .q_empty (job_empty)
  );

  arln_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (back_job),
    .job_empty (job_empty),
    .job_pop   (job_pop),
    .result    (result),
    .empty     (empty),
    .pop       (pop)
  );

endmodule
